FILE: hdl/wsfe_pkg.sv
`default_nettype none

package wsfe_pkg;

    localparam int LEN_W         = 28;
    localparam int QUEUE_DEPTH   = 4;

    // item kinds on the input tuser bit
    localparam logic OP_HEADER   = 1'b0;
    localparam logic OP_PAYLOAD  = 1'b1;

    localparam logic [7:0] TEXT_END = 8'hFF;
    localparam logic [7:0] CONT_BIT = 8'h80;
    localparam logic [6:0] GROUP_MASK = 7'h7F;

    // one classified input item, as the emitter needs it
    typedef struct packed {
        logic [7:0]       first_byte;  // type byte, payload byte or 0 for a stray byte
        logic [LEN_W-1:0] len;         // length for binary headers
        logic [2:0]       count;       // results for this item, 1..5
        logic [1:0]       grp_start;   // first length group sent
        logic             tail_ff;     // bytes after the first are 0xFF
        logic             err;
        logic             eof_last;    // end of frame on the final result
    } t_job;

endpackage

`default_nettype wire

FILE: hdl/wsfe_front.sv
`default_nettype none

module wsfe_front (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    input  wire                      i_opcode,
    input  wire [7:0]                i_frame_type,
    input  wire                      i_text_mode,
    input  wire [wsfe_pkg::LEN_W-1:0] i_payload_length,
    input  wire [7:0]                i_data_byte,
    output wsfe_pkg::t_job           o_job
);
    import wsfe_pkg::*;

    logic [LEN_W-1:0] r_remaining, n_remaining;
    logic             r_open, n_open;
    logic             r_is_text, n_is_text;
    logic             len_zero;
    logic             last_byte;

    assign len_zero  = (i_payload_length == '0);
    assign last_byte = (r_remaining == LEN_W'(1));

    always_comb begin
        n_remaining = r_remaining;
        n_open      = r_open;
        n_is_text   = r_is_text;
        o_job       = '0;
        if (i_opcode == OP_HEADER) begin
            o_job.first_byte = i_frame_type;
            o_job.len        = i_payload_length;
            o_job.err        = r_open;
            o_job.eof_last   = len_zero;
            o_job.tail_ff    = i_text_mode;
            if (i_text_mode) begin
                o_job.count     = len_zero ? 3'd2 : 3'd1;
                o_job.grp_start = 2'd3;
            end else begin
                // leading zero groups are dropped, the last group always goes out
                if (i_payload_length[27:21] != '0) begin
                    o_job.grp_start = 2'd0;
                end else if (i_payload_length[20:14] != '0) begin
                    o_job.grp_start = 2'd1;
                end else if (i_payload_length[13:7] != '0) begin
                    o_job.grp_start = 2'd2;
                end else begin
                    o_job.grp_start = 2'd3;
                end
                o_job.count = 3'd5 - {1'b0, o_job.grp_start};
            end
            n_remaining = i_payload_length;
            n_open      = !len_zero;
            n_is_text   = i_text_mode;
        end else if (!r_open || r_remaining == '0) begin
            // stray byte: dropped, one error result
            o_job.count     = 3'd1;
            o_job.err       = 1'b1;
            o_job.grp_start = 2'd3;
            n_open          = 1'b0;
            n_remaining     = '0;
        end else begin
            o_job.first_byte = i_data_byte;
            o_job.grp_start  = 2'd3;
            o_job.eof_last   = last_byte;
            o_job.tail_ff    = last_byte && r_is_text;
            o_job.count      = (last_byte && r_is_text) ? 3'd2 : 3'd1;
            n_remaining      = r_remaining - LEN_W'(1);
            if (last_byte) begin
                n_open    = 1'b0;
                n_is_text = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_open      <= 1'b0;
            r_is_text   <= 1'b0;
        end else if (i_valid) begin
            r_remaining <= n_remaining;
            r_open      <= n_open;
            r_is_text   <= n_is_text;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wsfe_queue.sv
`default_nettype none

module wsfe_queue #(
    parameter int DEPTH = wsfe_pkg::QUEUE_DEPTH
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  wire wsfe_pkg::t_job i_job,
    output logic               o_full,
    input  wire                i_pop,
    output logic               o_valid,
    output wsfe_pkg::t_job     o_job
);
    import wsfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wsfe_back.sv
`default_nettype none

module wsfe_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_job_valid,
    input  wire wsfe_pkg::t_job i_job,
    output logic               o_job_pop,
    output logic               o_valid,
    input  wire                i_ready,
    output logic [7:0]         o_byte,
    output logic               o_last,
    output logic               o_eof,
    output logic               o_err
);
    import wsfe_pkg::*;

    t_job       r_cur;
    logic       r_cur_valid;
    logic [2:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_byte;
    logic       r_last, r_eof, r_err;

    logic       advance;
    logic       final_res;
    logic [1:0] gi;
    logic [6:0] grp;
    logic [7:0] n_byte;

    assign advance   = !r_out_valid || i_ready;
    assign final_res = (r_idx == r_cur.count - 3'd1);
    assign o_job_pop = i_job_valid && (!r_cur_valid || (advance && final_res));

    assign gi = r_cur.grp_start + r_idx[1:0] - 2'd1;

    always_comb begin
        case (gi)
            2'd0:    grp = r_cur.len[27:21];
            2'd1:    grp = r_cur.len[20:14];
            2'd2:    grp = r_cur.len[13:7];
            default: grp = r_cur.len[6:0];
        endcase
        if (r_idx == '0) begin
            n_byte = r_cur.first_byte;
        end else if (r_cur.tail_ff) begin
            n_byte = TEXT_END;
        end else begin
            // continuation bit on every group but the last
            n_byte = {1'b0, grp & GROUP_MASK} | ((gi != 2'd3) ? CONT_BIT : 8'h00);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_cur_valid;
            end
            if (o_job_pop) begin
                r_cur_valid <= 1'b1;
                r_idx       <= '0;
            end else if (r_cur_valid && advance) begin
                if (final_res) begin
                    r_cur_valid <= 1'b0;
                    r_idx       <= '0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_cur <= i_job;
        end
        if (advance && r_cur_valid) begin
            r_byte <= n_byte;
            r_last <= final_res;
            r_eof  <= final_res && r_cur.eof_last;
            r_err  <= r_cur.err;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign o_eof   = r_eof;
    assign o_err   = r_err;

endmodule

`default_nettype wire

FILE: hdl/websocket_draft_frame_encoder_core.sv
`default_nettype none

// Early-draft WebSocket frame encoder. Each input transaction is either a frame
// header (tuser = 0) or one payload byte (tuser = 1). A header emits the frame
// type byte; a binary header then emits its length as big-endian base-128
// groups (bit 7 set on all but the last, leading zero groups dropped), and an
// empty text frame emits 0xFF right after the type byte. Payload bytes pass
// through while a 28-bit count runs down; the last byte of a text frame is
// followed by 0xFF. Output tlast marks the final byte produced by one input
// transaction; tuser flags end of frame and protocol errors (a payload byte
// with no open frame comes out as a single 0x00 with the error flag; a header
// that cuts an open frame short has the error flag on all of its bytes).
// Rate: the input side takes one transaction per cycle while the job queue
// (QUEUE_DEPTH entries) has room. The output emitter produces one byte per
// cycle while m_axis_tready is high and it has a job; a payload byte gives
// one byte (two for the last text byte) and a header 1 to 5, so sustained
// throughput is set by that emitter. Input passes the queue, job and output registers.

module websocket_draft_frame_encoder_core #(
    parameter int QUEUE_DEPTH = wsfe_pkg::QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] frame_type, [8] text_mode, [36:9] payload_length, [44:37] data_byte,
    // [47:45] zero
    input  wire [47:0]  s_axis_tdata,
    // [0] opcode
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]  m_axis_tdata,
    // last_of_run
    output logic        m_axis_tlast,
    // [0] end_of_frame, [1] protocol_error
    output logic [1:0]  m_axis_tuser
);
    import wsfe_pkg::*;

    t_job front_job;
    t_job queue_job;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic in_xfer;
    logic eof, err;

    assign s_axis_tready = !q_full;
    assign in_xfer       = s_axis_tvalid && !q_full;

    // classifier: owns the frame state, one decision per input transaction
    wsfe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (in_xfer),
        .i_opcode         (s_axis_tuser),
        .i_frame_type     (s_axis_tdata[7:0]),
        .i_text_mode      (s_axis_tdata[8]),
        .i_payload_length (s_axis_tdata[36:9]),
        .i_data_byte      (s_axis_tdata[44:37]),
        .o_job            (front_job)
    );

    // decouples header bursts from the input stream
    wsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (queue_job)
    );

    // byte emitter with registered output
    wsfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (queue_job),
        .o_job_pop   (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_eof       (eof),
        .o_err       (err)
    );

    assign m_axis_tuser = {err, eof};

endmodule

`default_nettype wire

FILE: bench/wsfe_stream_checker.sv
`default_nettype none

// Scoreboard for the frame encoder: predicts the encoded bytes of every input
// transaction and compares them in order with the output transactions.
module wsfe_stream_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    // [7:0] frame_type, [8] text_mode, [36:9] payload_length, [44:37] data_byte,
    // [47:45] zero
    input  wire [47:0]  i_s_tdata,
    // [0] opcode
    input  wire         i_s_tuser,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    // [7:0] out_byte
    input  wire [7:0]   i_m_tdata,
    input  wire         i_m_tlast,
    // [0] end_of_frame, [1] protocol_error
    input  wire [1:0]   i_m_tuser,
    output int          o_fail_count,
    output int          o_pending
);

    import wsfe_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eof;
        logic       err;
    } t_enc_byte;

    t_enc_byte        bytes_due[$];
    logic [LEN_W-1:0] bytes_left;
    logic             frame_open;
    logic             open_text;
    int               bytes_seen;

    function automatic t_enc_byte make_byte(input logic [7:0] data, input logic eof,
                                            input logic err);
        t_enc_byte b;
        b.data = data;
        b.last = 1'b0;
        b.eof  = eof;
        b.err  = err;
        return b;
    endfunction

    task automatic encode_item(input logic op, input logic [7:0] ftype, input logic text,
                               input logic [LEN_W-1:0] len, input logic [7:0] dbyte);
        t_enc_byte  run[$];
        logic [6:0] grp[4];
        logic       err;
        logic       final_byte;
        int         first;
        int         i;
        if (op == OP_HEADER) begin
            err = frame_open;
            run.push_back(make_byte(ftype, 1'b0, err));
            if (text) begin
                if (len == 0) run.push_back(make_byte(TEXT_END, 1'b1, err));
            end else begin
                // big-endian 7-bit groups, leading zero groups dropped
                for (i = 0; i < 4; i++) grp[i] = len[7 * (3 - i) +: 7];
                first = 3;
                for (i = 0; i < 3; i++) begin
                    if (first == 3 && grp[i] != 0) first = i;
                end
                for (i = first; i < 3; i++) run.push_back(make_byte(CONT_BIT | grp[i], 1'b0, err));
                run.push_back(make_byte({1'b0, grp[3]}, len == 0, err));
            end
            bytes_left = len;
            frame_open = (len != 0);
            open_text  = text;
        end else if (!frame_open || bytes_left == 0) begin
            // stray byte: dropped, one flagged zero byte
            frame_open = 1'b0;
            bytes_left = '0;
            run.push_back(make_byte(8'h00, 1'b0, 1'b1));
        end else begin
            bytes_left = bytes_left - 1'b1;
            final_byte = (bytes_left == 0);
            if (final_byte && open_text) begin
                run.push_back(make_byte(dbyte, 1'b0, 1'b0));
                run.push_back(make_byte(TEXT_END, 1'b1, 1'b0));
            end else begin
                run.push_back(make_byte(dbyte, final_byte, 1'b0));
            end
            if (final_byte) begin
                frame_open = 1'b0;
                open_text  = 1'b0;
            end
        end
        run[run.size() - 1].last = 1'b1;
        foreach (run[k]) bytes_due.push_back(run[k]);
    endtask

    task automatic report(input string what, input int want, input int got);
        $display("mismatch on output byte %0d, %s: expected 0x%0h, got 0x%0h",
                 bytes_seen, what, want, got);
        o_fail_count++;
    endtask

    task automatic check_byte();
        t_enc_byte want;
        if (bytes_due.size() == 0) begin
            report("no byte expected", 0, i_m_tdata);
        end else begin
            want = bytes_due.pop_front();
            if (i_m_tdata !== want.data) report("out_byte", want.data, i_m_tdata);
            if (i_m_tlast !== want.last) report("last_of_run", want.last, i_m_tlast);
            if (i_m_tuser[0] !== want.eof) report("end_of_frame", want.eof, i_m_tuser[0]);
            if (i_m_tuser[1] !== want.err) report("protocol_error", want.err, i_m_tuser[1]);
        end
        bytes_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bytes_due.delete();
            bytes_left   = '0;
            frame_open   = 1'b0;
            open_text    = 1'b0;
            bytes_seen   = 0;
            o_fail_count = 0;
            o_pending   <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                encode_item(i_s_tuser, i_s_tdata[7:0], i_s_tdata[8], i_s_tdata[36:9],
                            i_s_tdata[44:37]);
            end
            if (i_m_tvalid && i_m_tready) check_byte();
            o_pending <= bytes_due.size();
        end
    end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none

// Frame encoder bench: directed frames covering the edge cases, then random
// traffic, mostly well-formed frames plus cut frames and stray bytes.
// The checker module does all prediction and comparison.
module testbench;

    import wsfe_pkg::*;

    localparam int RANDOM_ITEMS = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    // [7:0] frame_type, [8] text_mode, [36:9] payload_length, [44:37] data_byte,
    // [47:45] zero
    logic [47:0] s_axis_tdata = '0;
    // [0] opcode
    logic        s_axis_tuser = OP_HEADER;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] out_byte
    wire  [7:0]  m_axis_tdata;
    wire         m_axis_tlast;
    // [0] end_of_frame, [1] protocol_error
    wire  [1:0]  m_axis_tuser;

    int fail_count;
    int bytes_pending;
    int burst_left = 0;
    int items_sent = 0;
    int ready_mode = 0;
    int mode_left = 0;

    websocket_draft_frame_encoder_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    wsfe_stream_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (bytes_pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: switches between always ready, coin flip, mostly ready and
    // long stalls, each held for a random stretch.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(8, 60);
        end
        mode_left--;
        case (ready_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // One input transaction. The sender runs in bursts; between bursts valid
    // drops for a random gap (often zero, sometimes long).
    task automatic drive_item(input logic op, input logic [7:0] ftype, input logic text,
                              input logic [LEN_W-1:0] len, input logic [7:0] dbyte);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, dbyte, len, text, ftype};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // header: data_byte is ignored, so it carries junk
    task automatic send_header(input logic [7:0] ftype, input logic text,
                               input logic [LEN_W-1:0] len);
        drive_item(OP_HEADER, ftype, text, len, 8'($urandom));
    endtask

    // payload: header fields are ignored, so they carry junk
    task automatic send_payload(input logic [7:0] dbyte);
        drive_item(OP_PAYLOAD, 8'($urandom), 1'($urandom), LEN_W'($urandom), dbyte);
    endtask

    // Hold input off until every predicted byte is out. The first edge makes
    // sure the count already includes the last accepted transaction.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (bytes_pending != 0);
    endtask

    initial begin
        int               random_start;
        int               cut_bytes;
        logic [LEN_W-1:0] len;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        send_payload(8'hFF);                    // stray byte right after reset
        send_header(8'h00, 1'b0, '0);           // empty binary frame
        send_header(8'hFF, 1'b1, '0);           // empty text frame
        send_header(8'h82, 1'b0, 28'd1);        // one-byte binary frame
        send_payload(8'h00);                    //   last binary byte
        send_header(8'h00, 1'b1, 28'd2);        // text frame, two bytes
        send_payload(8'hA5);
        send_payload(8'hFF);                    //   last text byte, then 0xFF
        send_header(8'hFF, 1'b0, '1);           // max length: four groups
        send_payload(8'h5A);
        send_header(8'h81, 1'b1, 28'd3);        // cuts the binary frame short
        send_payload(8'h3C);
        send_header(8'h01, 1'b0, 28'd128);      // cuts the text frame, two groups
        send_header(8'h02, 1'b0, 28'd16384);    // three groups
        send_header(8'h03, 1'b0, 28'd2097152);  // four groups
        send_header(8'h04, 1'b0, 28'd127);      // one group, all ones
        send_header(8'h05, 1'b0, 28'd2097151);
        send_header(8'h06, 1'b0, '0);           // empty frame that cuts one short
        send_payload(8'h77);                    // stray again
        send_header(8'h80, 1'b1, 28'd1);
        send_payload(8'h00);
        drain();

        // --- random ---
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    send_payload(8'($urandom));
                end
                2, 3: begin
                    // frame abandoned after a few bytes; lengths are full-range or 2..60 here
                    len = $urandom_range(0, 1) ? LEN_W'($urandom) : LEN_W'($urandom_range(2, 60));
                    send_header(8'($urandom), 1'($urandom), len);
                    cut_bytes = $urandom_range(0, 3);
                    repeat (cut_bytes) send_payload(8'($urandom));
                end
                4: begin
                    drain();
                end
                default: begin
                    len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(10, 40))
                                                      : LEN_W'($urandom_range(0, 5));
                    send_header(8'($urandom), 1'($urandom), len);
                    repeat (len) send_payload(8'($urandom));
                end
            endcase
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
